[hw/rtl/mec_pkg.sv]
// ----------------------------------------------------------------------------
// mec_pkg: shared types and constants of the enclosing circle search
// Point and job types passed between the loader, the queue and the search
// engine, plus the fixed widths of the determinant arithmetic.
// ----------------------------------------------------------------------------
package mec_pkg;

  // Integer bits allowed in a circumcentre coordinate before it is dropped.
  localparam int unsigned CENTRE_INT_BITS = 18;
  // Width of the doubled determinant of a triple.
  localparam int unsigned DET_W = 36;
  // Width of a circumcentre numerator.
  localparam int unsigned NUM_W = 52;
  // Width of a squared distance.
  localparam int unsigned SQ_W = 64;
  localparam logic [SQ_W-1:0] SQ_SAT = '1;

  // One stored point; x sits in the low half of the word.
  typedef struct packed {
    logic signed [15:0] y;
    logic signed [15:0] x;
  } point_t;

  typedef enum logic [1:0] {
    JOB_PAIR   = 2'd0,
    JOB_TRIPLE = 2'd1,
    JOB_END    = 2'd2
  } job_kind_e;

  // One queued candidate, or the end-of-set marker.
  typedef struct packed {
    job_kind_e kind;
    logic      single;
    logic      ovf;
    point_t    pa;
    point_t    pb;
    point_t    pc;
  } job_t;

endpackage

[hw/rtl/mec_store.sv]
// ----------------------------------------------------------------------------
// mec_store: point memory
// One write port and two registered read ports.
// ----------------------------------------------------------------------------
module mec_store import mec_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = 6
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  point_t           wr_data_i,
  input  logic [IDX_W-1:0] rd_a_addr_i,
  output point_t           rd_a_data_o,
  input  logic [IDX_W-1:0] rd_b_addr_i,
  output point_t           rd_b_data_o
);

  point_t mem_q [DEPTH];
  point_t rd_a_q;
  point_t rd_b_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Two read ports with registered data.
  always_ff @(posedge clk_i) begin
    rd_a_q <= mem_q[rd_a_addr_i];
    rd_b_q <= mem_q[rd_b_addr_i];
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule

[hw/rtl/mec_fifo.sv]
// ----------------------------------------------------------------------------
// mec_fifo: candidate queue
// Four-entry queue of jobs between the enumerator and the search engine.
// ----------------------------------------------------------------------------
module mec_fifo import mec_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned PTR_W = $clog2(QDEPTH);

  job_t               mem_q [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]     cnt_q;

  assign full_o  = (cnt_q == (PTR_W+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (PTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (PTR_W+1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[hw/rtl/mec_front.sv]
// ----------------------------------------------------------------------------
// mec_front: point loader and candidate enumerator
// Stores incoming points, then walks every pair and every triple, fetches
// their points and queues them as jobs, closing with an end marker.
// ----------------------------------------------------------------------------
module mec_front import mec_pkg::*; #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned IDX_W = 6,
  parameter int unsigned CNT_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [15:0]      x_i,
  input  logic [15:0]      y_i,
  input  logic             last_i,
  output logic             busy_o,
  output logic             wr_en_o,
  output logic [IDX_W-1:0] wr_addr_o,
  output point_t           wr_data_o,
  output logic [IDX_W-1:0] rd_addr_o,
  input  point_t           rd_data_i,
  output logic             push_o,
  output job_t             job_o,
  input  logic             full_i,
  input  logic             done_i,
  output logic [CNT_W-1:0] count_o
);

  localparam int unsigned CMP_W = CNT_W + 1;

  typedef enum logic [5:0] {
    FS_LOAD  = 6'b000001,
    FS_SETUP = 6'b000010,
    FS_FETCH = 6'b000100,
    FS_PUSH  = 6'b001000,
    FS_END   = 6'b010000,
    FS_WAIT  = 6'b100000
  } fstate_e;

  fstate_e          state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             single_q, single_d;
  logic             triple_q, triple_d;
  logic [1:0]       phase_q, phase_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  point_t           pa_q, pa_d, pb_q, pb_d, pc_q, pc_d;
  logic [CMP_W-1:0] cnt_w, i_w, j_w, k_w;

  assign cnt_w = CMP_W'(count_q);
  assign i_w   = CMP_W'(i_q);
  assign j_w   = CMP_W'(j_q);
  assign k_w   = CMP_W'(k_q);

  assign busy_o    = (state_q != FS_LOAD);
  assign wr_addr_o = count_q[IDX_W-1:0];
  assign wr_data_o = '{y: y_i, x: x_i};
  assign count_o   = count_q;

  // Loading, index walk and job issue.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    single_d  = single_q;
    triple_d  = triple_q;
    phase_d   = phase_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    pa_d      = pa_q;
    pb_d      = pb_q;
    pc_d      = pc_q;
    wr_en_o   = 1'b0;
    push_o    = 1'b0;
    rd_addr_o = i_q;
    job_o     = '{kind: JOB_END, single: single_q, ovf: ovf_q, pa: pa_q, pb: pb_q, pc: pc_q};
    unique case (state_q)
      FS_LOAD: begin
        if (start_i) begin
          if (count_q < CNT_W'(MAX_POINTS)) begin
            wr_en_o = 1'b1;
            count_d = count_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) begin
            state_d = FS_SETUP;
          end
        end
      end
      FS_SETUP: begin
        if (count_q == CNT_W'(1)) begin
          single_d = 1'b1;
          state_d  = FS_END;
        end else begin
          i_d      = '0;
          j_d      = IDX_W'(1);
          triple_d = 1'b0;
          phase_d  = 2'd0;
          state_d  = FS_FETCH;
        end
      end
      FS_FETCH: begin
        // Read data arrives in the cycle after its address.
        unique case (phase_q)
          2'd0: begin
            rd_addr_o = i_q;
            phase_d   = 2'd1;
          end
          2'd1: begin
            pa_d      = rd_data_i;
            rd_addr_o = j_q;
            phase_d   = 2'd2;
          end
          2'd2: begin
            pb_d      = rd_data_i;
            rd_addr_o = k_q;
            if (triple_q) begin
              phase_d = 2'd3;
            end else begin
              state_d = FS_PUSH;
            end
          end
          default: begin
            pc_d    = rd_data_i;
            state_d = FS_PUSH;
          end
        endcase
      end
      FS_PUSH: begin
        if (!full_i) begin
          push_o     = 1'b1;
          job_o.kind = triple_q ? JOB_TRIPLE : JOB_PAIR;
          phase_d    = 2'd0;
          state_d    = FS_FETCH;
          if (!triple_q) begin
            priority if (j_w + CMP_W'(1) < cnt_w) begin
              j_d = j_q + IDX_W'(1);
            end else if (i_w + CMP_W'(2) < cnt_w) begin
              i_d = i_q + IDX_W'(1);
              j_d = i_q + IDX_W'(2);
            end else if (cnt_w >= CMP_W'(3)) begin
              triple_d = 1'b1;
              i_d      = '0;
              j_d      = IDX_W'(1);
              k_d      = IDX_W'(2);
            end else begin
              state_d = FS_END;
            end
          end else begin
            priority if (k_w + CMP_W'(1) < cnt_w) begin
              k_d = k_q + IDX_W'(1);
            end else if (j_w + CMP_W'(2) < cnt_w) begin
              j_d = j_q + IDX_W'(1);
              k_d = j_q + IDX_W'(2);
            end else if (i_w + CMP_W'(3) < cnt_w) begin
              i_d = i_q + IDX_W'(1);
              j_d = i_q + IDX_W'(2);
              k_d = i_q + IDX_W'(3);
            end else begin
              state_d = FS_END;
            end
          end
        end
      end
      FS_END: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = FS_WAIT;
        end
      end
      FS_WAIT: begin
        if (done_i) begin
          count_d  = '0;
          ovf_d    = 1'b0;
          single_d = 1'b0;
          state_d  = FS_LOAD;
        end
      end
      default: begin
        state_d = FS_LOAD;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FS_LOAD;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      single_q <= 1'b0;
      triple_q <= 1'b0;
      phase_q  <= 2'd0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      single_q <= single_d;
      triple_q <= triple_d;
      phase_q  <= phase_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
    end
  end

  // Fetched points.
  always_ff @(posedge clk_i) begin
    pa_q <= pa_d;
    pb_q <= pb_d;
    pc_q <= pc_d;
  end

endmodule

[hw/rtl/mec_back.sv]
// ----------------------------------------------------------------------------
// mec_back: candidate search engine
// Builds each candidate centre, checks every stored point against it,
// keeps the smallest passing squared radius and takes its square root.
// ----------------------------------------------------------------------------
module mec_back import mec_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned IDX_W = 6,
  parameter int unsigned CNT_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [15:0]      tolerance_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic             empty_i,
  input  job_t             job_i,
  output logic             pop_o,
  output logic [IDX_W-1:0] rd_addr_o,
  input  point_t           rd_data_i,
  output logic             done_o,
  output logic [31:0]      radius_o,
  output logic             ovf_o
);

  localparam int unsigned NQ     = CENTRE_INT_BITS + FRAC_BITS + 1;
  localparam int unsigned CW     = NQ + 1;
  localparam int unsigned DIF_W  = (CW + 1 > 33) ? CW + 1 : 33;
  localparam int unsigned DCNT_W = $clog2(NQ + 1);
  localparam int unsigned LIM_W  = DET_W + CENTRE_INT_BITS + 1;

  typedef enum logic [10:0] {
    BS_IDLE  = 11'b00000000001,
    BS_DET1  = 11'b00000000010,
    BS_DET2  = 11'b00000000100,
    BS_DET3  = 11'b00000001000,
    BS_CHK   = 11'b00000010000,
    BS_DIVX  = 11'b00000100000,
    BS_DIVY  = 11'b00001000000,
    BS_ANCH  = 11'b00010000000,
    BS_R2    = 11'b00100000000,
    BS_SWEEP = 11'b01000000000,
    BS_SQRT  = 11'b10000000000
  } bstate_e;

  bstate_e state_q, state_d;

  // Job registers.
  point_t pa_q, pa_d, pb_q, pb_d, pc_q, pc_d;
  logic   job_ovf_q, job_ovf_d;

  // Determinant pipeline.
  logic signed [32:0]      sa_q, sb_q, sc_q;
  logic signed [16:0]      dy_bc_q, dy_ca_q, dy_ab_q, dx_cb_q, dx_ac_q, dx_ba_q;
  logic signed [32:0]      pd1_q, pd2_q, pd3_q;
  logic signed [49:0]      nt1_q, nt2_q, nt3_q, mt1_q, mt2_q, mt3_q;
  logic signed [DET_W-1:0] det_q;
  logic signed [NUM_W-1:0] nx_q, ny_q;

  // Divider and centre.
  logic [DET_W-1:0]        ud, ud_q, ud_d;
  logic [NUM_W-1:0]        unx, uny;
  logic                    far_x, far_y;
  logic [DET_W:0]          dv_r_q, dv_r_d, dv_t, dv_rn;
  logic [NQ-1:0]           dv_s_q, dv_s_d, dv_q_q, dv_q_d, dv_qn;
  logic [DCNT_W-1:0]       dv_cnt_q, dv_cnt_d;
  logic                    dv_neg_q, dv_neg_d, dv_ge, dv_last;
  logic [NQ:0]             dv_rnd;
  logic signed [CW-1:0]    dv_res;
  logic signed [CW-1:0]    cx_q, cx_d, cy_q, cy_d;
  logic signed [16:0]      sum_x, sum_y;

  // Distance pipeline.
  logic                    dp_v;
  point_t                  dp_pt;
  logic signed [DIF_W-1:0] dfx, dfy;
  logic [DIF_W-1:0]        mgx, mgy;
  logic                    da_v_q, da_sat_q, db_v_q, db_sat_q, dc_v_q;
  logic [31:0]             da_ux_q, da_uy_q;
  logic [SQ_W-1:0]         db_sqx_q, db_sqy_q, dc_d_q;
  logic [SQ_W:0]           dc_sum;

  // Search bookkeeping.
  logic [SQ_W-1:0]         best_q, best_d, r2_q, r2_d, lim_q, lim_d;
  logic [SQ_W:0]           lim_sum;
  logic [CNT_W-1:0]        iss_q, iss_d, ret_q, ret_d;
  logic                    rd_v_q, rd_en, fail_q, fail_d, fail_now;

  // Square root.
  logic [SQ_W-1:0]         sq_v_q, sq_v_d, sq_res_q, sq_res_d, sq_bit_q, sq_bit_d, sq_t;
  logic [SQ_W-1:0]         sq_res_n;

  // Result registers.
  logic                    done_q, done_d, ovfo_q, ovfo_d;
  logic [31:0]             radius_q, radius_d;

  // Determinant, numerators and their differences, three registered stages.
  always_ff @(posedge clk_i) begin
    sa_q    <= 33'(pa_q.x) * 33'(pa_q.x) + 33'(pa_q.y) * 33'(pa_q.y);
    sb_q    <= 33'(pb_q.x) * 33'(pb_q.x) + 33'(pb_q.y) * 33'(pb_q.y);
    sc_q    <= 33'(pc_q.x) * 33'(pc_q.x) + 33'(pc_q.y) * 33'(pc_q.y);
    dy_bc_q <= 17'(pb_q.y) - 17'(pc_q.y);
    dy_ca_q <= 17'(pc_q.y) - 17'(pa_q.y);
    dy_ab_q <= 17'(pa_q.y) - 17'(pb_q.y);
    dx_cb_q <= 17'(pc_q.x) - 17'(pb_q.x);
    dx_ac_q <= 17'(pa_q.x) - 17'(pc_q.x);
    dx_ba_q <= 17'(pb_q.x) - 17'(pa_q.x);
    pd1_q   <= 33'(pa_q.x) * 33'(dy_bc_q);
    pd2_q   <= 33'(pb_q.x) * 33'(dy_ca_q);
    pd3_q   <= 33'(pc_q.x) * 33'(dy_ab_q);
    nt1_q   <= 50'(sa_q) * 50'(dy_bc_q);
    nt2_q   <= 50'(sb_q) * 50'(dy_ca_q);
    nt3_q   <= 50'(sc_q) * 50'(dy_ab_q);
    mt1_q   <= 50'(sa_q) * 50'(dx_cb_q);
    mt2_q   <= 50'(sb_q) * 50'(dx_ac_q);
    mt3_q   <= 50'(sc_q) * 50'(dx_ba_q);
    det_q   <= (DET_W'(pd1_q) + DET_W'(pd2_q) + DET_W'(pd3_q)) <<< 1;
    nx_q    <= NUM_W'(nt1_q) + NUM_W'(nt2_q) + NUM_W'(nt3_q);
    ny_q    <= NUM_W'(mt1_q) + NUM_W'(mt2_q) + NUM_W'(mt3_q);
  end

  // Magnitudes and the far-centre test.
  assign ud    = det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);
  assign unx   = nx_q[NUM_W-1] ? NUM_W'(-nx_q) : NUM_W'(nx_q);
  assign uny   = ny_q[NUM_W-1] ? NUM_W'(-ny_q) : NUM_W'(ny_q);
  assign far_x = LIM_W'(unx) >= (LIM_W'(ud) << CENTRE_INT_BITS);
  assign far_y = LIM_W'(uny) >= (LIM_W'(ud) << CENTRE_INT_BITS);

  // One restoring division step, and the rounded signed centre.
  assign dv_t    = {dv_r_q[DET_W-1:0], dv_s_q[NQ-1]};
  assign dv_ge   = dv_t >= (DET_W+1)'(ud_q);
  assign dv_rn   = dv_ge ? dv_t - (DET_W+1)'(ud_q) : dv_t;
  assign dv_qn   = {dv_q_q[NQ-2:0], dv_ge};
  assign dv_last = (dv_cnt_q == DCNT_W'(NQ - 1));
  assign dv_rnd  = (NQ+1)'(dv_qn) + (NQ+1)'(1);
  assign dv_res  = dv_neg_q ? -$signed(CW'(dv_rnd[NQ:1])) : $signed(CW'(dv_rnd[NQ:1]));

  // Pair midpoint.
  assign sum_x = 17'(job_i.pa.x) + 17'(job_i.pb.x);
  assign sum_y = 17'(job_i.pa.y) + 17'(job_i.pb.y);

  // Distance pipeline, stage one: offsets and their magnitudes.
  assign dfx = (DIF_W'($signed(dp_pt.x)) <<< FRAC_BITS) - DIF_W'(cx_q);
  assign dfy = (DIF_W'($signed(dp_pt.y)) <<< FRAC_BITS) - DIF_W'(cy_q);
  assign mgx = dfx[DIF_W-1] ? DIF_W'(-dfx) : DIF_W'(dfx);
  assign mgy = dfy[DIF_W-1] ? DIF_W'(-dfy) : DIF_W'(dfy);
  assign dc_sum = (SQ_W+1)'(db_sqx_q) + (SQ_W+1)'(db_sqy_q);

  always_ff @(posedge clk_i) begin
    da_ux_q  <= mgx[31:0];
    da_uy_q  <= mgy[31:0];
    da_sat_q <= (|mgx[DIF_W-1:32]) | (|mgy[DIF_W-1:32]);
    db_sqx_q <= SQ_W'(da_ux_q) * SQ_W'(da_ux_q);
    db_sqy_q <= SQ_W'(da_uy_q) * SQ_W'(da_uy_q);
    db_sat_q <= da_sat_q;
    dc_d_q   <= (db_sat_q || dc_sum[SQ_W]) ? SQ_SAT : dc_sum[SQ_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      da_v_q <= 1'b0;
      db_v_q <= 1'b0;
      dc_v_q <= 1'b0;
      rd_v_q <= 1'b0;
    end else begin
      da_v_q <= dp_v;
      db_v_q <= da_v_q;
      dc_v_q <= db_v_q;
      rd_v_q <= rd_en;
    end
  end

  // Squared radius plus slack, saturating.
  assign lim_sum = (SQ_W+1)'(dc_d_q) + (SQ_W+1)'(tolerance_i);

  // Sweep compare.
  assign fail_now = fail_q || (dc_d_q == SQ_SAT) || (dc_d_q > lim_q);

  // Square root step.
  assign sq_t     = sq_res_q + sq_bit_q;
  assign sq_res_n = (sq_v_q >= sq_t) ? (sq_res_q >> 1) + sq_bit_q : (sq_res_q >> 1);

  assign rd_en     = (state_q == BS_SWEEP) && (iss_q < count_i);
  assign rd_addr_o = iss_q[IDX_W-1:0];

  // Search sequencer.
  always_comb begin
    state_d   = state_q;
    pa_d      = pa_q;
    pb_d      = pb_q;
    pc_d      = pc_q;
    job_ovf_d = job_ovf_q;
    ud_d      = ud_q;
    dv_r_d    = dv_r_q;
    dv_s_d    = dv_s_q;
    dv_q_d    = dv_q_q;
    dv_cnt_d  = dv_cnt_q;
    dv_neg_d  = dv_neg_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    best_d    = best_q;
    r2_d      = r2_q;
    lim_d     = lim_q;
    iss_d     = iss_q;
    ret_d     = ret_q;
    fail_d    = fail_q;
    sq_v_d    = sq_v_q;
    sq_res_d  = sq_res_q;
    sq_bit_d  = sq_bit_q;
    done_d    = 1'b0;
    radius_d  = radius_q;
    ovfo_d    = ovfo_q;
    pop_o     = 1'b0;
    dp_v      = 1'b0;
    dp_pt     = rd_data_i;
    unique case (state_q)
      BS_IDLE: begin
        if (!empty_i) begin
          pop_o     = 1'b1;
          pa_d      = job_i.pa;
          pb_d      = job_i.pb;
          pc_d      = job_i.pc;
          job_ovf_d = job_i.ovf;
          unique case (job_i.kind)
            JOB_PAIR: begin
              cx_d    = CW'(sum_x) <<< (FRAC_BITS - 1);
              cy_d    = CW'(sum_y) <<< (FRAC_BITS - 1);
              state_d = BS_ANCH;
            end
            JOB_TRIPLE: begin
              state_d = BS_DET1;
            end
            JOB_END: begin
              sq_v_d   = job_i.single ? '0 : best_q;
              sq_res_d = '0;
              sq_bit_d = SQ_W'(1) << (SQ_W - 2);
              state_d  = BS_SQRT;
            end
            default: begin
              state_d = BS_IDLE;
            end
          endcase
        end
      end
      BS_DET1: state_d = BS_DET2;
      BS_DET2: state_d = BS_DET3;
      BS_DET3: state_d = BS_CHK;
      BS_CHK: begin
        // Collinear or far triples are dropped.
        if ((det_q == '0) || far_x || far_y) begin
          state_d = BS_IDLE;
        end else begin
          ud_d     = ud;
          dv_r_d   = (DET_W+1)'(unx >> CENTRE_INT_BITS);
          dv_s_d   = {unx[CENTRE_INT_BITS-1:0], (FRAC_BITS+1)'(0)};
          dv_q_d   = '0;
          dv_cnt_d = '0;
          dv_neg_d = nx_q[NUM_W-1] ^ det_q[DET_W-1];
          state_d  = BS_DIVX;
        end
      end
      BS_DIVX: begin
        dv_r_d   = dv_rn;
        dv_s_d   = dv_s_q << 1;
        dv_q_d   = dv_qn;
        dv_cnt_d = dv_cnt_q + DCNT_W'(1);
        if (dv_last) begin
          cx_d     = dv_res;
          dv_r_d   = (DET_W+1)'(uny >> CENTRE_INT_BITS);
          dv_s_d   = {uny[CENTRE_INT_BITS-1:0], (FRAC_BITS+1)'(0)};
          dv_q_d   = '0;
          dv_cnt_d = '0;
          dv_neg_d = ny_q[NUM_W-1] ^ det_q[DET_W-1];
          state_d  = BS_DIVY;
        end
      end
      BS_DIVY: begin
        dv_r_d   = dv_rn;
        dv_s_d   = dv_s_q << 1;
        dv_q_d   = dv_qn;
        dv_cnt_d = dv_cnt_q + DCNT_W'(1);
        if (dv_last) begin
          cy_d    = dv_res;
          state_d = BS_ANCH;
        end
      end
      BS_ANCH: begin
        dp_v    = 1'b1;
        dp_pt   = pa_q;
        state_d = BS_R2;
      end
      BS_R2: begin
        if (dc_v_q) begin
          if ((dc_d_q == SQ_SAT) || (dc_d_q >= best_q)) begin
            state_d = BS_IDLE;
          end else begin
            r2_d    = dc_d_q;
            lim_d   = lim_sum[SQ_W] ? SQ_SAT : lim_sum[SQ_W-1:0];
            iss_d   = '0;
            ret_d   = '0;
            fail_d  = 1'b0;
            state_d = BS_SWEEP;
          end
        end
      end
      BS_SWEEP: begin
        dp_v = rd_v_q;
        if (rd_en) begin
          iss_d = iss_q + CNT_W'(1);
        end
        if (dc_v_q) begin
          fail_d = fail_now;
          ret_d  = ret_q + CNT_W'(1);
          if (ret_q + CNT_W'(1) == count_i) begin
            if (!fail_now) begin
              best_d = r2_q;
            end
            state_d = BS_IDLE;
          end
        end
      end
      BS_SQRT: begin
        if (sq_v_q >= sq_t) begin
          sq_v_d = sq_v_q - sq_t;
        end
        sq_res_d = sq_res_n;
        sq_bit_d = sq_bit_q >> 2;
        if (sq_bit_q[0]) begin
          done_d   = 1'b1;
          radius_d = sq_res_n[31:0];
          ovfo_d   = job_ovf_q;
          best_d   = SQ_SAT;
          state_d  = BS_IDLE;
        end
      end
      default: begin
        state_d = BS_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BS_IDLE;
      best_q   <= SQ_SAT;
      dv_cnt_q <= '0;
      iss_q    <= '0;
      ret_q    <= '0;
      fail_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      best_q   <= best_d;
      dv_cnt_q <= dv_cnt_d;
      iss_q    <= iss_d;
      ret_q    <= ret_d;
      fail_q   <= fail_d;
      done_q   <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    pa_q      <= pa_d;
    pb_q      <= pb_d;
    pc_q      <= pc_d;
    job_ovf_q <= job_ovf_d;
    ud_q      <= ud_d;
    dv_r_q    <= dv_r_d;
    dv_s_q    <= dv_s_d;
    dv_q_q    <= dv_q_d;
    dv_neg_q  <= dv_neg_d;
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    r2_q      <= r2_d;
    lim_q     <= lim_d;
    sq_v_q    <= sq_v_d;
    sq_res_q  <= sq_res_d;
    sq_bit_q  <= sq_bit_d;
    radius_q  <= radius_d;
    ovfo_q    <= ovfo_d;
  end

  assign done_o   = done_q;
  assign radius_o = radius_q;
  assign ovf_o    = ovfo_q;

endmodule

[hw/rtl/min_enclosing_circle_brute.sv]
// ----------------------------------------------------------------------------
// min_enclosing_circle_brute: minimum enclosing circle by exhaustive search
// Top level: tolerance register, point memory, enumerator, job queue and
// search engine.
// ----------------------------------------------------------------------------
// Points are taken one per cycle while busy is low. The word marked last
// starts the search, and busy stays high until the radius appears on
// radius_q16_o for the single cycle that done_o is high; the receiver must
// take it then. The search time grows with the set size N, set by the
// per-candidate sweep through the memory's second read port and, for
// triples, the bit-serial divider for the circumcentre; a bit-serial
// square root then closes the search. The point memory needs no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module min_enclosing_circle_brute import mec_pkg::*; #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] x_coord_i,
  input  logic [15:0] y_coord_i,
  input  logic        last_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  output logic        done_o,
  output logic [31:0] radius_q16_o,
  output logic        overflowed_o
);

  localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  logic [15:0]      tol_q;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr, rd_a_addr, rd_b_addr;
  point_t           wr_data, rd_a_data, rd_b_data;
  logic             push, pop, full, empty, search_done;
  job_t             push_job, pop_job;
  logic [CNT_W-1:0] count;

  // Tolerance register; a word is taken whenever offered.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= 16'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= cfg_data_i;
    end
  end

  mec_store #(
    .DEPTH (MAX_POINTS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_a_addr_i (rd_a_addr),
    .rd_a_data_o (rd_a_data),
    .rd_b_addr_i (rd_b_addr),
    .rd_b_data_o (rd_b_data)
  );

  mec_front #(
    .MAX_POINTS (MAX_POINTS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .x_i       (x_coord_i),
    .y_i       (y_coord_i),
    .last_i    (last_i),
    .busy_o    (busy),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_addr_o (rd_a_addr),
    .rd_data_i (rd_a_data),
    .push_o    (push),
    .job_o     (push_job),
    .full_i    (full),
    .done_i    (search_done),
    .count_o   (count)
  );

  mec_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_job),
    .empty_o (empty)
  );

  mec_back #(
    .FRAC_BITS (FRAC_BITS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tolerance_i (tol_q),
    .count_i     (count),
    .empty_i     (empty),
    .job_i       (pop_job),
    .pop_o       (pop),
    .rd_addr_o   (rd_b_addr),
    .rd_data_i   (rd_b_data),
    .done_o      (search_done),
    .radius_o    (radius_q16_o),
    .ovf_o       (overflowed_o)
  );

  assign done_o = search_done;

  // A word marked last always starts a search.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_i) |=> busy)
    else $error("search did not start after the last word");

  // The result is a single-cycle strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // A result only appears while the loader is held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result produced while accepting points");

  // The queue is never written when full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push)
    else $error("job queue overrun");

endmodule
